// ===== sv/ttsd_pkg.sv =====
// Package: segment codes and digit encoder for the temperature segment core.
package ttsd_pkg;

    localparam int unsigned RAW_W   = 12;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned CENTI_W = 14;

    localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    // Largest magnitude in hundredths of a degree (reading of -2048).
    localparam logic [CENTI_W-1:0] CENTI_MAX = 14'd12800;

    typedef logic [SEG_W-1:0] seg_t;
    typedef logic [3:0]       digit_t;

    // Common-cathode segment pattern of one decimal digit.
    function automatic seg_t seg_encode(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/temperature_to_segment_digits_core.sv =====
// Top level: signed temperature reading to seven-segment digit bytes.
//
// Takes one signed 12-bit reading in sixteenths of a degree per transaction
// and returns its magnitude in hundredths of a degree (truncated), five
// seven-segment bytes for that value (the units-of-degree digit carries the
// decimal point), a sign byte (minus bar or blank) and a sign flag. The core
// is a two-register pipeline: an input register, a short conversion path and
// a result register. It accepts one transaction every cycle while the output
// side is not stalled, moving each one from input to result register; the
// input register keeps taking data while a finished result waits, so a stall
// on m_ tready backs up into s_tready only once both registers are full.
// The magnitude is split into whole degrees and a sixteenths remainder, so the
// digits come from small constant-divisor steps on 8-bit and 7-bit values.
module temperature_to_segment_digits_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] raw_reading (signed), [15:12] zero
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] sign_pattern, [15:8] seg_ten_thousands,
                                   // [23:16] seg_thousands, [31:24] seg_hundreds_point,
                                   // [39:32] seg_tens, [47:40] seg_units,
                                   // [61:48] centi_magnitude, [63:62] zero
    output logic [0:0]  m_tuser    // [0] is_negative
);
    import ttsd_pkg::*;

    // Input register stage.
    logic                    in_valid_reg;
    logic signed [RAW_W-1:0] raw_reg;

    // Result register stage.
    logic                    out_valid_reg;
    seg_t                    sign_reg;
    seg_t                    seg_tt_reg;
    seg_t                    seg_th_reg;
    seg_t                    seg_hp_reg;
    seg_t                    seg_tens_reg;
    seg_t                    seg_units_reg;
    logic [CENTI_W-1:0]      centi_reg;
    logic                    neg_reg;

    // Conversion path.
    logic                    neg_next;
    logic [RAW_W-1:0]        mag;
    logic [7:0]              whole_deg;   // 0 to 128
    logic [3:0]              frac16;
    logic [8:0]              frac_x25;
    logic [6:0]              frac_centi;  // 0 to 93
    logic [14:0]             frac_prod;
    digit_t                  d_tens;
    digit_t                  d_units;
    logic                    d_hundred;
    logic [6:0]              whole_rem;   // 0 to 99
    logic [14:0]             whole_prod;
    digit_t                  d_tens_deg;
    digit_t                  d_units_deg;
    logic [16:0]             mag_x25;
    logic [CENTI_W-1:0]      centi_next;

    logic                    out_load;

    // Advance the input register into the result register whenever the
    // result slot is empty or being drained this cycle.
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (out_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            raw_reg <= s_tdata[RAW_W-1:0];
        end
    end

    always_comb begin
        neg_next = raw_reg[RAW_W-1];
        // Two's complement magnitude; -2048 maps to 2048, which fits 12 bits.
        mag = neg_next ? (~raw_reg + 12'd1) : raw_reg;

        // Exact scaled magnitude: floor(mag * 25 / 4).
        mag_x25    = {5'd0, mag} * 17'd25;
        centi_next = mag_x25[15:2];

        // Fraction: sixteenths to hundredths, always below 100.
        whole_deg  = mag[11:4];
        frac16     = mag[3:0];
        frac_x25   = {5'd0, frac16} * 9'd25;
        frac_centi = frac_x25[8:2];
        // Divide by ten through the reciprocal 205/2048, exact below 1024.
        frac_prod  = {8'd0, frac_centi} * 15'd205;
        d_tens     = frac_prod[14:11];
        d_units    = 4'(frac_centi - 7'(d_tens) * 7'd10);

        // Whole degrees: at most 128, so the hundreds digit is 0 or 1.
        d_hundred   = (whole_deg >= 8'd100);
        whole_rem   = d_hundred ? 7'(whole_deg - 8'd100) : whole_deg[6:0];
        whole_prod  = {8'd0, whole_rem} * 15'd205;
        d_tens_deg  = whole_prod[14:11];
        d_units_deg = 4'(whole_rem - 7'(d_tens_deg) * 7'd10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result payload while the downstream side stalls.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            sign_reg      <= neg_next ? SEG_MINUS : SEG_BLANK;
            seg_tt_reg    <= seg_encode({3'd0, d_hundred});
            seg_th_reg    <= seg_encode(d_tens_deg);
            seg_hp_reg    <= seg_encode(d_units_deg) | SEG_POINT;
            seg_tens_reg  <= seg_encode(d_tens);
            seg_units_reg <= seg_encode(d_units);
            centi_reg     <= centi_next;
            neg_reg       <= neg_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, centi_reg, seg_units_reg, seg_tens_reg,
                       seg_hp_reg, seg_th_reg, seg_tt_reg, sign_reg};
    assign m_tuser  = neg_reg;

endmodule

// ===== sv/ttsd_checker.sv =====
// Port checker for the temperature segment core, with its bind.
module ttsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import ttsd_pkg::*;

    // A stalled result stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Sign byte agrees with the sign flag.
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] && m_tdata[7:0] == SEG_MINUS) ||
                     (!m_tuser[0] && m_tdata[7:0] == SEG_BLANK))
        else $error("sign byte and sign flag disagree");

    // Point lit on the degree digit, magnitude in range, padding clear.
    a_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31] && m_tdata[61:48] <= CENTI_MAX &&
                     m_tdata[63:62] == 2'b00)
        else $error("malformed result");

    // A result needs an accepted reading first: nothing valid just after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind temperature_to_segment_digits_core ttsd_checker u_ttsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
